@@ hw/rtl/btbp_pkg.sv @@
// ----------------------------------------------------------------------------
// btbp_pkg
// Shared types and constants for the two-level branch predictor with BTB.
// ----------------------------------------------------------------------------
package btbp_pkg;

   // configuration register indexes (byte address = 4 * index)
   localparam logic [2:0] REG_ENTRIES_LOG2   = 3'd0;
   localparam logic [2:0] REG_HISTORY_LEN    = 3'd1;
   localparam logic [2:0] REG_TAG_WIDTH      = 3'd2;
   localparam logic [2:0] REG_COUNTER_INIT   = 3'd3;
   localparam logic [2:0] REG_GLOBAL_HISTORY = 3'd4;
   localparam logic [2:0] REG_GLOBAL_TABLE   = 3'd5;
   localparam logic [2:0] REG_SHARE_MODE     = 3'd6;

   localparam int CSR_ADDR_W = 5;

   // global table index modes
   localparam logic [1:0] SHARE_HIST   = 2'd0;
   localparam logic [1:0] SHARE_GSHARE = 2'd1;
   localparam logic [1:0] SHARE_LSHARE = 2'd2;

   localparam logic [1:0] CNT_MAX = 2'd3;
   localparam logic [1:0] CNT_MIN = 2'd0;
   localparam logic [1:0] CNT_WEAK_NT = 2'd1;
   localparam logic [31:0] PC_STEP = 32'd4;

   typedef struct packed {
      logic [2:0] entries_log2;
      logic [3:0] history_len;
      logic [4:0] tag_width;
      logic [1:0] counter_init;
      logic       global_history;
      logic       global_table;
      logic [1:0] share_mode;
   } cfg_type;

   typedef enum logic [8:0] {
      ST_CLEAR = 9'b000000001,
      ST_IDLE  = 9'b000000010,
      ST_LOOK  = 9'b000000100,
      ST_PRED  = 9'b000001000,
      ST_UPD   = 9'b000010000,
      ST_FILL  = 9'b000100000,
      ST_READ  = 9'b001000000,
      ST_TRAIN = 9'b010000000,
      ST_DONE  = 9'b100000000
   } state_type;

   typedef struct packed {
      logic capture;
      logic clr_start;
      logic clear_wr;
      logic look;
      logic pred;
      logic upd;
      logic fill_wr;
      logic rd_ci;
      logic train;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic in_update;
      logic fill_needed;
      logic clear_last;
      logic fill_last;
      logic out_free;
   } sts_type;

endpackage

@@ hw/rtl/btbp_req_if.sv @@
// ----------------------------------------------------------------------------
// btbp_req_if
// Request channel: predict or update item with valid/ready.
// ----------------------------------------------------------------------------
interface btbp_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [31:0] pc;
   logic [31:0] target_pc;
   logic        taken;
   logic [31:0] predicted_dest;

   modport source(output valid, req_type, pc, target_pc, taken, predicted_dest,
                  input ready);
   modport sink(input valid, req_type, pc, target_pc, taken, predicted_dest,
                output ready);
endinterface

@@ hw/rtl/btbp_rsp_if.sv @@
// ----------------------------------------------------------------------------
// btbp_rsp_if
// Result channel: prediction and statistics with valid/ready.
// ----------------------------------------------------------------------------
interface btbp_rsp_if;
   logic        valid;
   logic        ready;
   logic        predict_taken;
   logic [31:0] dest_out;
   logic        flush;
   logic [31:0] branch_count;
   logic [31:0] mispredict_count;

   modport source(output valid, predict_taken, dest_out, flush, branch_count,
                  mispredict_count, input ready);
   modport sink(input valid, predict_taken, dest_out, flush, branch_count,
                mispredict_count, output ready);
endinterface

@@ hw/rtl/btbp_csr.sv @@
// ----------------------------------------------------------------------------
// btbp_csr
// APB-style configuration registers.
// ----------------------------------------------------------------------------
module btbp_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [btbp_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [31:0]                          pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready,
   output btbp_pkg::cfg_type                    cfg,
   output logic                                 init_wr
);
   btbp_pkg::cfg_type cfg_ff, cfg_in;
   logic              wr;
   logic [2:0]        idx;

   assign pready = 1'b1;
   assign idx    = paddr[4:2];
   assign wr     = psel & penable & pwrite;
   assign init_wr = wr && (idx == btbp_pkg::REG_COUNTER_INIT);
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (idx)
            btbp_pkg::REG_ENTRIES_LOG2:   cfg_in.entries_log2   = pwdata[2:0];
            btbp_pkg::REG_HISTORY_LEN:    cfg_in.history_len    = pwdata[3:0];
            btbp_pkg::REG_TAG_WIDTH:      cfg_in.tag_width      = pwdata[4:0];
            btbp_pkg::REG_COUNTER_INIT:   cfg_in.counter_init   = pwdata[1:0];
            btbp_pkg::REG_GLOBAL_HISTORY: cfg_in.global_history = pwdata[0];
            btbp_pkg::REG_GLOBAL_TABLE:   cfg_in.global_table   = pwdata[0];
            btbp_pkg::REG_SHARE_MODE:     cfg_in.share_mode     = pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = 32'd0;
      unique case (idx)
         btbp_pkg::REG_ENTRIES_LOG2:   prdata = {29'd0, cfg_ff.entries_log2};
         btbp_pkg::REG_HISTORY_LEN:    prdata = {28'd0, cfg_ff.history_len};
         btbp_pkg::REG_TAG_WIDTH:      prdata = {27'd0, cfg_ff.tag_width};
         btbp_pkg::REG_COUNTER_INIT:   prdata = {30'd0, cfg_ff.counter_init};
         btbp_pkg::REG_GLOBAL_HISTORY: prdata = {31'd0, cfg_ff.global_history};
         btbp_pkg::REG_GLOBAL_TABLE:   prdata = {31'd0, cfg_ff.global_table};
         btbp_pkg::REG_SHARE_MODE:     prdata = {30'd0, cfg_ff.share_mode};
         default: prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.entries_log2   <= 3'd4;
         cfg_ff.history_len    <= 4'd2;
         cfg_ff.tag_width      <= 5'd8;
         cfg_ff.counter_init   <= btbp_pkg::CNT_WEAK_NT;
         cfg_ff.global_history <= 1'b0;
         cfg_ff.global_table   <= 1'b0;
         cfg_ff.share_mode     <= btbp_pkg::SHARE_HIST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule

@@ hw/rtl/btbp_ctrl.sv @@
// ----------------------------------------------------------------------------
// btbp_ctrl
// Sequencer: clear sweep, predict lookup, update with optional row fill.
// ----------------------------------------------------------------------------
module btbp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              init_wr,
   input  btbp_pkg::sts_type sts,
   output btbp_pkg::cmd_type cmd,
   output logic              req_ready
);
   btbp_pkg::state_type state_ff, state_in;

   assign req_ready = (state_ff == btbp_pkg::ST_IDLE);

   always_comb begin
      cmd           = '0;
      cmd.capture   = (state_ff == btbp_pkg::ST_IDLE) && req_valid;
      cmd.clr_start = init_wr;
      cmd.clear_wr  = (state_ff == btbp_pkg::ST_CLEAR);
      cmd.look      = (state_ff == btbp_pkg::ST_LOOK);
      cmd.pred      = (state_ff == btbp_pkg::ST_PRED);
      cmd.upd       = (state_ff == btbp_pkg::ST_UPD);
      cmd.fill_wr   = (state_ff == btbp_pkg::ST_FILL);
      cmd.rd_ci     = (state_ff == btbp_pkg::ST_READ);
      cmd.train     = (state_ff == btbp_pkg::ST_TRAIN);
      cmd.load_out  = (state_ff == btbp_pkg::ST_DONE) && sts.out_free;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         btbp_pkg::ST_CLEAR: if (sts.clear_last) state_in = btbp_pkg::ST_IDLE;
         btbp_pkg::ST_IDLE: begin
            if (req_valid)
               state_in = sts.in_update ? btbp_pkg::ST_UPD : btbp_pkg::ST_LOOK;
         end
         btbp_pkg::ST_LOOK: state_in = btbp_pkg::ST_PRED;
         btbp_pkg::ST_PRED: state_in = btbp_pkg::ST_DONE;
         btbp_pkg::ST_UPD: begin
            state_in = sts.fill_needed ? btbp_pkg::ST_FILL : btbp_pkg::ST_READ;
         end
         btbp_pkg::ST_FILL: if (sts.fill_last) state_in = btbp_pkg::ST_READ;
         btbp_pkg::ST_READ: state_in = btbp_pkg::ST_TRAIN;
         btbp_pkg::ST_TRAIN: state_in = btbp_pkg::ST_DONE;
         btbp_pkg::ST_DONE: if (sts.out_free) state_in = btbp_pkg::ST_IDLE;
         default: state_in = btbp_pkg::ST_CLEAR;
      endcase
      if (init_wr) state_in = btbp_pkg::ST_CLEAR;
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= btbp_pkg::ST_CLEAR;
      else       state_ff <= state_in;
   end

   a_fill_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == btbp_pkg::ST_FILL && sts.fill_last && !init_wr)
      |=> state_ff == btbp_pkg::ST_READ)
      else $error("fill sweep did not hand over to counter read");

   a_accept_route: assert property (@(posedge clock) disable iff (reset)
      (cmd.capture && !init_wr) |=>
      (state_ff == btbp_pkg::ST_LOOK || state_ff == btbp_pkg::ST_UPD))
      else $error("accepted request not dispatched");

   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == btbp_pkg::ST_CLEAR) |-> !req_ready)
      else $error("request taken during clear sweep");
endmodule

@@ hw/rtl/btbp_dp.sv @@
// ----------------------------------------------------------------------------
// btbp_dp
// Datapath: BTB arrays, histories, counter memory, statistics, result reg.
// ----------------------------------------------------------------------------
module btbp_dp #(
   parameter int MAX_ENTRIES  = 32,
   parameter int MAX_HISTORY  = 8,
   parameter int MAX_TAG      = 30,
   parameter int LSHARE_SHIFT = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  btbp_pkg::cfg_type cfg,
   input  btbp_pkg::cmd_type cmd,
   output btbp_pkg::sts_type sts,
   input  logic              req_type,
   input  logic [31:0]       req_pc,
   input  logic [31:0]       req_target_pc,
   input  logic              req_taken,
   input  logic [31:0]       req_predicted_dest,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic              rsp_predict_taken,
   output logic [31:0]       rsp_dest_out,
   output logic              rsp_flush,
   output logic [31:0]       rsp_branch_count,
   output logic [31:0]       rsp_mispredict_count
);
   localparam int EW        = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int LOG_MAX   = $clog2(MAX_ENTRIES + 1) - 1;
   localparam int HW        = MAX_HISTORY;
   localparam int TW        = MAX_TAG;
   localparam int CNT_DEPTH = MAX_ENTRIES * (1 << HW);
   localparam int CW        = EW + HW;

   // BTB arrays
   logic [TW-1:0] tag_ff  [MAX_ENTRIES];
   logic [31:0]   tgt_ff  [MAX_ENTRIES];
   logic [HW-1:0] hist_ff [MAX_ENTRIES];
   logic [1:0]    cnt_mem [CNT_DEPTH];

   // captured request
   logic [31:0] pc_ff, target_ff, pdest_ff;
   logic        taken_ff;

   // lookup memory of the last predict
   logic [EW-1:0] last_entry_ff;
   logic [TW-1:0] last_tag_ff;
   logic          last_miss_ff, last_taken_ff;

   logic          hit_ff;
   logic [31:0]   hit_tgt_ff;
   logic [CW-1:0] ci_ff, sweep_ff;
   logic [1:0]    rd_ff;
   logic [31:0]   upd_total_ff, fl_total_ff;
   logic          res_pt_ff, res_fl_ff;
   logic [31:0]   res_dest_ff;

   logic          out_valid_ff, out_pt_ff, out_fl_ff;
   logic [31:0]   out_dest_ff, out_bc_ff, out_fc_ff;

   // effective configuration
   logic [3:0]    k_eff;
   logic [3:0]    hl_eff;
   logic [4:0]    tw_eff;
   logic [EW-1:0] emask;
   logic [HW-1:0] hmask;
   logic [TW-1:0] tmask;

   // lookup path
   logic [EW-1:0] l_entry, l_slot;
   logic [31:0]   l_shift;
   logic [TW-1:0] l_tag;
   logic          l_hit;
   logic [HW-1:0] l_hist;
   logic [CW-1:0] l_ci;

   // update path
   logic [EW-1:0] u_slot;
   logic [HW-1:0] u_old, u_new;
   logic [CW-1:0] u_ci;
   logic          u_fl;

   logic [CW-1:0] mem_ra, mem_wa;
   logic          mem_we;
   logic [1:0]    mem_wd, trained;

   function automatic logic [CW-1:0] cnt_index(
      input logic          gt,
      input logic [1:0]    sm,
      input logic [EW-1:0] entry,
      input logic [31:0]   pc,
      input logic [HW-1:0] hist,
      input logic [HW-1:0] m
   );
      logic [31:0] g_pc, l_pc;
      g_pc = pc >> 2;
      l_pc = pc >> LSHARE_SHIFT;
      if (!gt) return {entry, hist};
      case (sm)
         btbp_pkg::SHARE_GSHARE: return {{EW{1'b0}}, (g_pc[HW-1:0] & m) ^ hist};
         btbp_pkg::SHARE_LSHARE: return {{EW{1'b0}}, (l_pc[HW-1:0] & m) ^ hist};
         default:                return {{EW{1'b0}}, hist};
      endcase
   endfunction

   always_comb begin
      k_eff  = ({1'b0, cfg.entries_log2} > 4'(LOG_MAX)) ? 4'(LOG_MAX)
                                                        : {1'b0, cfg.entries_log2};
      hl_eff = (cfg.history_len > 4'(MAX_HISTORY)) ? 4'(MAX_HISTORY) : cfg.history_len;
      tw_eff = (cfg.tag_width > 5'(MAX_TAG)) ? 5'(MAX_TAG) : cfg.tag_width;
      emask  = ~({EW{1'b1}} << k_eff);
      hmask  = ~({HW{1'b1}} << hl_eff);
      tmask  = ~({TW{1'b1}} << tw_eff);
   end

   always_comb begin
      l_entry = pc_ff[EW+1:2] & emask;
      l_shift = pc_ff >> (k_eff + 4'd2);
      l_tag   = l_shift[TW-1:0] & tmask;
      l_hit   = (l_tag == tag_ff[l_entry]);
      l_slot  = cfg.global_history ? '0 : l_entry;
      l_hist  = hist_ff[l_slot] & hmask;
      l_ci    = cnt_index(cfg.global_table, cfg.share_mode, l_entry, pc_ff, l_hist,
                          hmask);
   end

   always_comb begin
      u_slot = cfg.global_history ? '0 : last_entry_ff;
      u_old  = (last_miss_ff && !cfg.global_history) ? '0 : (hist_ff[u_slot] & hmask);
      u_new  = HW'({u_old, taken_ff}) & hmask;
      u_ci   = cnt_index(cfg.global_table, cfg.share_mode, last_entry_ff, pc_ff,
                         u_old, hmask);
      u_fl   = (last_taken_ff != taken_ff) ||
               (last_taken_ff && taken_ff && (pdest_ff != target_ff));
   end

   always_comb begin
      trained = rd_ff;
      if (taken_ff && rd_ff != btbp_pkg::CNT_MAX) trained = rd_ff + 2'd1;
      else if (!taken_ff && rd_ff != btbp_pkg::CNT_MIN) trained = rd_ff - 2'd1;
      mem_ra = cmd.rd_ci ? ci_ff : l_ci;
      mem_we = cmd.clear_wr | cmd.fill_wr | cmd.train;
      mem_wa = cmd.train ? ci_ff : sweep_ff;
      mem_wd = cmd.train ? trained : cfg.counter_init;
   end

   always_comb begin
      sts.in_update   = req_type;
      sts.fill_needed = last_miss_ff && !cfg.global_table;
      sts.clear_last  = (sweep_ff == CW'(CNT_DEPTH - 1));
      sts.fill_last   = &sweep_ff[HW-1:0];
      sts.out_free    = !out_valid_ff || rsp_ready;
   end

   // counter memory
   always_ff @(posedge clock) begin
      if (mem_we) cnt_mem[mem_wa] <= mem_wd;
      rd_ff <= cnt_mem[mem_ra];
   end

   // BTB arrays have a defined reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            tag_ff[i]  <= '0;
            tgt_ff[i]  <= '0;
            hist_ff[i] <= '0;
         end
      end else if (cmd.upd) begin
         if (last_miss_ff) tag_ff[last_entry_ff] <= last_tag_ff;
         if (last_miss_ff || (taken_ff && target_ff != pdest_ff))
            tgt_ff[last_entry_ff] <= target_ff;
         hist_ff[u_slot] <= u_new;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         pc_ff    <= req_pc;
         target_ff <= req_target_pc;
         taken_ff <= req_taken;
         pdest_ff <= req_predicted_dest;
      end
      if (cmd.look) begin
         hit_ff     <= l_hit;
         hit_tgt_ff <= tgt_ff[l_entry];
      end
      if (cmd.upd) ci_ff <= u_ci;
      if (cmd.pred) begin
         res_pt_ff   <= hit_ff && rd_ff[1];
         res_dest_ff <= (hit_ff && rd_ff[1]) ? hit_tgt_ff : pc_ff + btbp_pkg::PC_STEP;
         res_fl_ff   <= 1'b0;
      end
      if (cmd.upd) begin
         res_pt_ff   <= 1'b0;
         res_dest_ff <= '0;
         res_fl_ff   <= u_fl;
      end
      if (cmd.load_out) begin
         out_pt_ff   <= res_pt_ff;
         out_dest_ff <= res_dest_ff;
         out_fl_ff   <= res_fl_ff;
         out_bc_ff   <= upd_total_ff;
         out_fc_ff   <= fl_total_ff;
      end
   end

   // control and predictor state
   always_ff @(posedge clock) begin
      if (reset) begin
         last_entry_ff <= '0;
         last_tag_ff   <= '0;
         last_miss_ff  <= 1'b0;
         last_taken_ff <= 1'b0;
         upd_total_ff  <= '0;
         fl_total_ff   <= '0;
         sweep_ff      <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (cmd.look) begin
            last_entry_ff <= l_entry;
            last_tag_ff   <= l_tag;
            last_miss_ff  <= !l_hit;
         end
         if (cmd.pred) last_taken_ff <= hit_ff && rd_ff[1];
         if (cmd.upd) begin
            upd_total_ff <= upd_total_ff + 32'd1;
            if (u_fl) fl_total_ff <= fl_total_ff + 32'd1;
         end
         if (cmd.clr_start)
            sweep_ff <= '0;
         else if (cmd.upd)
            sweep_ff <= {last_entry_ff, {HW{1'b0}}};
         else if (cmd.clear_wr || cmd.fill_wr)
            sweep_ff <= sweep_ff + CW'(1);
         if (cmd.load_out)   out_valid_ff <= 1'b1;
         else if (rsp_ready) out_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_predict_taken    = out_pt_ff;
   assign rsp_dest_out         = out_dest_ff;
   assign rsp_flush            = out_fl_ff;
   assign rsp_branch_count     = out_bc_ff;
   assign rsp_mispredict_count = out_fc_ff;

   a_flush_with_update: assert property (@(posedge clock) disable iff (reset)
      (fl_total_ff != $past(fl_total_ff)) |-> (upd_total_ff != $past(upd_total_ff)))
      else $error("flush count moved without an update");

   a_fill_in_row: assert property (@(posedge clock) disable iff (reset)
      cmd.fill_wr |-> (sweep_ff[CW-1:HW] == last_entry_ff))
      else $error("row fill left its row");

   a_miss_dest: assert property (@(posedge clock) disable iff (reset)
      (cmd.pred && !hit_ff) |=> (res_dest_ff == pc_ff + btbp_pkg::PC_STEP && !res_pt_ff))
      else $error("BTB miss did not fall through");
endmodule

@@ hw/rtl/btb_two_level_branch_predictor.sv @@
// ----------------------------------------------------------------------------
// btb_two_level_branch_predictor
// Direct-mapped BTB with local/global history and 2-bit counter tables.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries predict (req_type 0) and update (req_type 1) items; a
//   transfer happens when valid and ready are both high. Each item gives one
//   transfer on rsp_chan. An update trains the entry looked up by the most
//   recent predict.
//   A predict goes from its transfer to its result through capture,
//   BTB/history lookup with counter read, decision and result load.
//   An update goes through capture, state write, counter read, counter
//   train and result load; an update after a miss with per-entry tables
//   first walks the entry's counter row. Items are handled one at a time:
//   a new one is taken only once the previous one has loaded its result
//   and the sequencer is back in idle.
//   Reset: the counter memory is swept to counter_init, one entry a cycle,
//   over all MAX_ENTRIES * 2^MAX_HISTORY entries, with req ready low. A
//   write of counter_init starts the same sweep again.
//   Stall: the result register holds while rsp ready is low; the next item
//   may still be taken and worked on, and waits for the register to free.
// ----------------------------------------------------------------------------
module btb_two_level_branch_predictor #(
   parameter int MAX_ENTRIES  = 32,
   parameter int MAX_HISTORY  = 8,
   parameter int MAX_TAG      = 30,
   parameter int LSHARE_SHIFT = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   btbp_req_if.sink                        req_chan,
   btbp_rsp_if.source                      rsp_chan,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [btbp_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);
   btbp_pkg::cfg_type cfg;
   btbp_pkg::cmd_type cmd;
   btbp_pkg::sts_type sts;
   logic              init_wr;

   // configuration registers; counter_init writes kick a clear sweep
   btbp_csr u_csr (
      .clock, .reset, .psel, .penable, .pwrite, .paddr, .pwdata,
      .prdata, .pready, .cfg, .init_wr
   );

   // sequencer
   btbp_ctrl u_ctrl (
      .clock, .reset,
      .req_valid (req_chan.valid),
      .init_wr,
      .sts,
      .cmd,
      .req_ready (req_chan.ready)
   );

   // arrays, counter memory and result register
   btbp_dp #(
      .MAX_ENTRIES  (MAX_ENTRIES),
      .MAX_HISTORY  (MAX_HISTORY),
      .MAX_TAG      (MAX_TAG),
      .LSHARE_SHIFT (LSHARE_SHIFT)
   ) u_dp (
      .clock, .reset, .cfg, .cmd, .sts,
      .req_type             (req_chan.req_type),
      .req_pc               (req_chan.pc),
      .req_target_pc        (req_chan.target_pc),
      .req_taken            (req_chan.taken),
      .req_predicted_dest   (req_chan.predicted_dest),
      .rsp_ready            (rsp_chan.ready),
      .rsp_valid            (rsp_chan.valid),
      .rsp_predict_taken    (rsp_chan.predict_taken),
      .rsp_dest_out         (rsp_chan.dest_out),
      .rsp_flush            (rsp_chan.flush),
      .rsp_branch_count     (rsp_chan.branch_count),
      .rsp_mispredict_count (rsp_chan.mispredict_count)
   );
endmodule

@@ test/btbp_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// btbp_checker
// Watches the request, result and CSR traffic of the branch predictor, keeps
// its own model of BTB, history and counter state, and compares every result
// transfer against the oldest predicted outcome.
// ----------------------------------------------------------------------------
module btbp_checker (
   input  logic        clock,
   input  logic        reset,
   btbp_req_if         req,
   btbp_rsp_if         rsp,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic        pready,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output int          fail_count,
   output int          pending
);
   localparam int ROW = 256;
   localparam int DEPTH = 32 * ROW;

   typedef struct packed {
      logic        predict_taken;
      logic [31:0] dest_out;
      logic        flush;
      logic [31:0] branch_count;
      logic [31:0] mispredict_count;
   } outcome_type;

   outcome_type outcome_q[$];

   // shadow configuration
   logic [2:0] c_elog;
   logic [3:0] c_hlen;
   logic [4:0] c_tagw;
   logic [1:0] c_cinit;
   logic       c_ghist, c_gtab;
   logic [1:0] c_share;

   // shadow predictor state
   logic [29:0] tags[32];
   logic [31:0] targets[32];
   logic [7:0]  hists[32];
   logic [1:0]  ctrs[DEPTH];
   logic [4:0]  last_entry;
   logic [29:0] last_tag;
   logic        last_miss, last_taken;
   logic [31:0] branches, flushes;
   int          mismatches;

   function automatic logic [7:0] hist_mask();
      int h;
      h = (c_hlen > 8) ? 8 : c_hlen;
      return 8'((9'd1 << h) - 9'd1);
   endfunction

   function automatic int counter_slot(input logic [4:0] ent, input logic [31:0] pc,
                                       input logic [7:0] h);
      logic [7:0] m;
      logic [7:0] hv;
      m = hist_mask();
      hv = h & m;
      if (!c_gtab) return ent * ROW + hv;
      if (c_share == btbp_pkg::SHARE_GSHARE) return ((pc >> 2) & m) ^ hv;
      if (c_share == btbp_pkg::SHARE_LSHARE) return ((pc >> 16) & m) ^ hv;
      return hv;
   endfunction

   function automatic outcome_type predict_branch(input logic [31:0] pc);
      outcome_type o;
      int k, tw;
      logic [4:0] ent;
      logic [29:0] tg;
      logic [63:0] wide;
      k = (c_elog > 5) ? 5 : c_elog;
      tw = (c_tagw > 30) ? 30 : c_tagw;
      ent = 5'((pc >> 2) & ((32'd1 << k) - 1));
      wide = {32'd0, pc} >> (k + 2);
      tg = 30'(wide & ((64'd1 << tw) - 1));
      o = '0;
      o.dest_out = pc + btbp_pkg::PC_STEP;
      if (tg != tags[ent]) begin
         last_miss = 1'b1;
      end else begin
         o.predict_taken =
            ctrs[counter_slot(ent, pc, hists[c_ghist ? 0 : ent])] > btbp_pkg::CNT_WEAK_NT;
         if (o.predict_taken) o.dest_out = targets[ent];
         last_miss = 1'b0;
      end
      last_entry = ent;
      last_tag = tg;
      last_taken = o.predict_taken;
      o.branch_count = branches;
      o.mispredict_count = flushes;
      return o;
   endfunction

   function automatic outcome_type resolve_branch(input logic [31:0] pc,
                                                  input logic [31:0] tgt,
                                                  input logic tk, input logic [31:0] pdest);
      outcome_type o;
      logic [4:0] ent;
      logic [4:0] slot;
      logic [7:0] old;
      int ci;
      ent = last_entry;
      o = '0;
      o.flush = (last_taken != tk) || (last_taken && tk && pdest != tgt);
      branches++;
      if (o.flush) flushes++;
      if (last_miss) begin
         tags[ent] = last_tag;
         targets[ent] = tgt;
         if (!c_ghist) hists[ent] = '0;
         if (!c_gtab)
            for (int j = 0; j < ROW; j++) ctrs[ent * ROW + j] = c_cinit;
      end
      if (tk && tgt != pdest) targets[ent] = tgt;
      slot = c_ghist ? 5'd0 : ent;
      old = hists[slot] & hist_mask();
      hists[slot] = ((old << 1) | 8'(tk)) & hist_mask();
      ci = counter_slot(ent, pc, old);
      if (tk && ctrs[ci] < btbp_pkg::CNT_MAX) ctrs[ci]++;
      else if (!tk && ctrs[ci] > btbp_pkg::CNT_MIN) ctrs[ci]--;
      o.branch_count = branches;
      o.mispredict_count = flushes;
      return o;
   endfunction

   always @(posedge clock) begin
      outcome_type got, want, nxt;
      if (reset) begin
         c_elog = 3'd4; c_hlen = 4'd2; c_tagw = 5'd8; c_cinit = btbp_pkg::CNT_WEAK_NT;
         c_ghist = 0; c_gtab = 0; c_share = btbp_pkg::SHARE_HIST;
         for (int i = 0; i < 32; i++) begin
            tags[i] = '0; targets[i] = '0; hists[i] = '0;
         end
         for (int i = 0; i < DEPTH; i++) ctrs[i] = c_cinit;
         last_entry = '0; last_tag = '0; last_miss = 0; last_taken = 0;
         branches = '0; flushes = '0;
         outcome_q.delete();
         fail_count = 0; mismatches = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[4:2])
               btbp_pkg::REG_ENTRIES_LOG2:   c_elog = pwdata[2:0];
               btbp_pkg::REG_HISTORY_LEN:    c_hlen = pwdata[3:0];
               btbp_pkg::REG_TAG_WIDTH:      c_tagw = pwdata[4:0];
               btbp_pkg::REG_COUNTER_INIT: begin
                  c_cinit = pwdata[1:0];
                  for (int i = 0; i < DEPTH; i++) ctrs[i] = c_cinit;
               end
               btbp_pkg::REG_GLOBAL_HISTORY: c_ghist = pwdata[0];
               btbp_pkg::REG_GLOBAL_TABLE:   c_gtab = pwdata[0];
               btbp_pkg::REG_SHARE_MODE:     c_share = pwdata[1:0];
               default: ;
            endcase
         end
         // a result leaves only after its request has passed the sequencer's lookup or
         // update states, so order within this edge does not matter
         if (rsp.valid && rsp.ready) begin
            got = {rsp.predict_taken, rsp.dest_out, rsp.flush, rsp.branch_count,
                   rsp.mispredict_count};
            if (outcome_q.size() == 0) begin
               fail_count++;
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result transfer: taken %0d dest %h flush %0d bc %0d fc %0d",
                           got.predict_taken, got.dest_out, got.flush,
                           got.branch_count, got.mispredict_count);
            end else begin
               want = outcome_q.pop_front();
               if (got != want) begin
                  fail_count++;
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp taken %0d dest %h flush %0d bc %0d fc %0d / ",
                              want.predict_taken, want.dest_out, want.flush,
                              want.branch_count, want.mispredict_count,
                              "got taken %0d dest %h flush %0d bc %0d fc %0d",
                              got.predict_taken, got.dest_out, got.flush,
                              got.branch_count, got.mispredict_count);
               end
            end
         end
         if (req.valid && req.ready) begin
            if (req.req_type)
               nxt = resolve_branch(req.pc, req.target_pc, req.taken, req.predicted_dest);
            else
               nxt = predict_branch(req.pc);
            outcome_q = {outcome_q, nxt};
         end
      end
      pending = outcome_q.size();
   end

endmodule

@@ test/btb_two_level_branch_predictor_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// btb_two_level_branch_predictor_tb
// Drives predict/update pairs, stray items and CSR settings into the branch
// predictor; a checker module beside the DUT predicts and compares results.
// ----------------------------------------------------------------------------
module btb_two_level_branch_predictor_tb;
   localparam int PHASES = 7;
   localparam int ITEMS_PER_PHASE = 200;
   localparam int POOL = 16;

   logic        clock = 0;
   logic        reset;
   logic        psel, penable, pwrite;
   logic [4:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;
   int          fail_count, pending;
   int          burst_left = 0;

   // per-phase branch working set: address, usual target, taken bias
   logic [31:0] pool_pc[POOL];
   logic [31:0] pool_tgt[POOL];
   int          pool_bias[POOL];

   // settings per phase: elog, hlen, tagw, cinit, ghist, gtab, share
   // phase 0 runs on reset values; oversized fields show up in later phases
   int settings[PHASES][7] = '{
      '{4, 2, 8, 1, 0, 0, 0},
      '{0, 1, 0, 0, 0, 0, 0},
      '{5, 8, 30, 3, 1, 1, 1},
      '{7, 15, 31, 2, 0, 1, 2},
      '{3, 0, 4, 1, 1, 0, 3},
      '{6, 4, 12, 3, 0, 1, 1},
      '{2, 8, 2, 0, 1, 1, 2}
   };

   btbp_req_if req_chan();
   btbp_rsp_if rsp_chan();

   always #5 clock = ~clock;

   btb_two_level_branch_predictor DUT (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   btbp_checker checker_i (
      .clock(clock), .reset(reset), .req(req_chan), .rsp(rsp_chan),
      .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
      .paddr(paddr), .pwdata(pwdata), .fail_count(fail_count), .pending(pending)
   );

   // Receiver stall pattern: switches at random between always ready,
   // random stalls and long stalls.
   int stall_mode = 0;
   int stall_timer = 0;
   always @(posedge clock) begin
      if (stall_timer == 0) begin
         stall_mode <= $urandom_range(0, 2);
         stall_timer <= $urandom_range(50, 400);
      end else begin
         stall_timer <= stall_timer - 1;
      end
      case (stall_mode)
         0: rsp_chan.ready <= 1'b1;
         1: rsp_chan.ready <= ($urandom_range(0, 9) < 7);
         default: rsp_chan.ready <= ($urandom_range(0, 9) == 0);
      endcase
   end

   // Sender: bursts of random length, random gaps between them.
   // valid stays high across back-to-back transfers.
   task automatic send_item(input logic ty, input logic [31:0] pc, input logic [31:0] tgt,
                            input logic tk, input logic [31:0] pdest);
      if (burst_left == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 40);
      end
      req_chan.valid <= 1'b1;
      req_chan.req_type <= ty;
      req_chan.pc <= pc;
      req_chan.target_pc <= tgt;
      req_chan.taken <= tk;
      req_chan.predicted_dest <= pdest;
      // ready is stable by the falling edge; the transfer is at the next rise
      do @(negedge clock); while (!req_chan.ready);
      @(posedge clock);
      burst_left--;
   endtask

   // hold the sender until every result is back, plus settle margin
   task automatic drain();
      req_chan.valid <= 1'b0;
      burst_left = 0;
      do @(negedge clock); while (pending != 0);
      repeat (12) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input int value);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {idx, 2'b00}; pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_setting(input int p);
      csr_write(btbp_pkg::REG_ENTRIES_LOG2, settings[p][0]);
      csr_write(btbp_pkg::REG_HISTORY_LEN, settings[p][1]);
      csr_write(btbp_pkg::REG_TAG_WIDTH, settings[p][2]);
      csr_write(btbp_pkg::REG_COUNTER_INIT, settings[p][3]);
      csr_write(btbp_pkg::REG_GLOBAL_HISTORY, settings[p][4]);
      csr_write(btbp_pkg::REG_GLOBAL_TABLE, settings[p][5]);
      csr_write(btbp_pkg::REG_SHARE_MODE, settings[p][6]);
   endtask

   // Working set: some low addresses below 1024 (small tags; the lowest hit right
   // after reset), some aliasing the same entry, the rest fully random.
   task automatic build_pool();
      for (int i = 0; i < POOL; i++) begin
         case (i % 4)
            0: pool_pc[i] = $urandom_range(0, 255) << 2;
            1: pool_pc[i] = (i > 1) ? (pool_pc[i - 1] ^ ($urandom << 9)) : $urandom;
            default: pool_pc[i] = $urandom;
         endcase
         pool_tgt[i] = $urandom;
         pool_bias[i] = $urandom_range(0, 10);
      end
   endtask

   task automatic random_item();
      int i, r;
      logic [31:0] pdest;
      logic tk;
      i = $urandom_range(0, POOL - 1);
      r = $urandom_range(0, 99);
      tk = ($urandom_range(0, 9) < pool_bias[i]);
      case ($urandom_range(0, 2))
         0: pdest = pool_tgt[i];
         1: pdest = pool_pc[i] + 4;
         default: pdest = $urandom;
      endcase
      if ($urandom_range(0, 19) == 0) pool_tgt[i] = $urandom;
      if (r < 85) begin
         // well-formed predict followed by its update
         send_item(1'b0, pool_pc[i], $urandom, 1'($urandom), $urandom);
         send_item(1'b1, pool_pc[i], pool_tgt[i], tk, pdest);
      end else if (r < 92) begin
         send_item(1'b0, $urandom, $urandom, 1'($urandom), $urandom);
      end else begin
         // update with no fresh predict reuses the previous lookup
         send_item(1'b1, $urandom, $urandom, 1'($urandom), $urandom);
      end
   endtask

   initial begin
      reset = 1'b1;
      psel <= 0; penable <= 0; pwrite <= 0; paddr <= '0; pwdata <= '0;
      req_chan.valid <= 0; req_chan.req_type <= 0; req_chan.pc <= '0;
      req_chan.target_pc <= '0; req_chan.taken <= 0; req_chan.predicted_dest <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: zero-tag hit after reset, update without predict,
      // address and target extremes, direction and target mispredicts
      send_item(1'b1, 32'h0, 32'hFFFF_FFFF, 1'b1, 32'h0);
      send_item(1'b0, 32'h0, 32'h0, 1'b0, 32'h0);
      send_item(1'b1, 32'h0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
      send_item(1'b0, 32'h0, 32'h0, 1'b0, 32'h0);
      send_item(1'b1, 32'h0, 32'h1234_5678, 1'b1, 32'hFFFF_FFFF);
      send_item(1'b0, 32'h0, 32'h0, 1'b0, 32'h0);
      send_item(1'b1, 32'h0, 32'h1234_5678, 1'b0, 32'h1234_5678);
      send_item(1'b0, 32'hFFFF_FFFF, 32'h0, 1'b0, 32'h0);
      send_item(1'b1, 32'hFFFF_FFFF, 32'h0, 1'b1, 32'hFFFF_FFFF);
      send_item(1'b0, 32'hFFFF_FFFF, 32'h0, 1'b1, 32'h0);
      send_item(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFC, 1'b1, 32'h0);
      send_item(1'b0, 32'hFFFF_FFFC, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
      send_item(1'b1, 32'hFFFF_FFFC, 32'hFFFF_FFFF, 1'b0, 32'h0);
      send_item(1'b1, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 32'h5555_5555);
      send_item(1'b0, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 32'h0);
      send_item(1'b1, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 32'h0);

      for (int p = 0; p < PHASES; p++) begin
         if (p > 0) begin
            drain();
            apply_setting(p);
         end
         build_pool();
         for (int n = 0; n < ITEMS_PER_PHASE; n += 2) begin
            // mid-phase: hold off until the block has caught up
            if (n == ITEMS_PER_PHASE / 2) drain();
            random_item();
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("btb_two_level_branch_predictor test passed");
      else
         $display("btb_two_level_branch_predictor test failed");
      $finish;
   end

   // Watchdog: worst case is every update filling a 256-counter row behind
   // long result stalls, plus a full counter sweep per phase.
   initial begin
      #30ms;
      $display("btb_two_level_branch_predictor test failed");
      $finish;
   end

endmodule
